FILE: rtl/chta_pkg.sv
// ----------------------------------------------------------------------------
// chta_pkg
// Shared types and constants of the clustered hash table core.
// ----------------------------------------------------------------------------
package chta_pkg;

  localparam int KEY_W   = 64;
  localparam int MOVE_W  = 16;
  localparam int DEPTH_W = 8;
  localparam int DATE_W  = 4;
  localparam int FLAG_W  = 4;
  localparam int VALUE_W = 16;
  localparam int USED_W  = 17;
  localparam int SCORE_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_STORE    = 2'd0;
  localparam logic [1:0] OP_RETRIEVE = 2'd1;
  localparam logic [1:0] OP_ADVANCE  = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SMART_MOVE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMART_VALUE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMART_REPLACE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_WRITE  = 2'd3;

  localparam logic signed [DEPTH_W-1:0] DEPTH_NONE = -8'sd128;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN  = -16'sd32767;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move;
    logic signed [DEPTH_W-1:0] depth;
    logic [DATE_W-1:0]         date;
    logic [FLAG_W-1:0]         flags;
    logic [VALUE_W-1:0]        value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_CLEAR = '{
    key: '0, move: '0, depth: DEPTH_NONE, date: '0, flags: '0, value: '0};

endpackage

FILE: rtl/chta_req_if.sv
// ----------------------------------------------------------------------------
// chta_req_if
// Request channel: operation, key and entry fields to store.
// ----------------------------------------------------------------------------
interface chta_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] key;
  logic [15:0] move_in;
  logic [6:0]  depth_in;
  logic [3:0]  flags_in;
  logic signed [15:0] value_in;

  modport source (output valid, op, key, move_in, depth_in, flags_in, value_in,
                  input ready);
  modport sink   (input valid, op, key, move_in, depth_in, flags_in, value_in,
                  output ready);
endinterface

FILE: rtl/chta_rsp_if.sv
// ----------------------------------------------------------------------------
// chta_rsp_if
// Response channel: lookup result and used entry count.
// ----------------------------------------------------------------------------
interface chta_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] move_out;
  logic signed [7:0]  depth_out;
  logic [3:0]  flags_out;
  logic signed [15:0] value_out;
  logic [16:0] used_count;

  modport source (output valid, hit, move_out, depth_out, flags_out, value_out,
                  used_count, input ready);
  modport sink   (input valid, hit, move_out, depth_out, flags_out, value_out,
                  used_count, output ready);
endinterface

FILE: rtl/chta_ram.sv
// ----------------------------------------------------------------------------
// chta_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/clustered_hash_table_age_replace_core.sv
// ----------------------------------------------------------------------------
// clustered_hash_table_age_replace_core
// Clustered hash table with age and depth based victim selection.
// Retrieve and store read the bucket's ways, one way read a cycle; a store
//   then makes at most one write back. Advance steps the date; clear writes
//   every entry, one entry cleared a cycle.
// One request in flight; the next is taken the cycle after the response is
//   registered.
// Reset runs the same clearing sweep; no request is taken until it ends.
// ----------------------------------------------------------------------------
module clustered_hash_table_age_replace_core
  import chta_pkg::*;
#(
  parameter int INDEX_BITS = 16,
  parameter int WAYS       = 4,
  parameter int AGE_SLOTS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  chta_req_if.sink             req,
  chta_rsp_if.source           rsp
);

  localparam int DEPTH = (1 << INDEX_BITS) + WAYS - 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(WAYS + 1);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_SCAN, S_WRITE, S_DONE} state_t;

  state_t state;

  logic smart_move, smart_value, smart_replace, always_write;
  logic [DATE_W-1:0] cur_date;
  logic [USED_W-1:0] used_counter;

  logic [1:0]         op_r;
  logic [KEY_W-1:0]   key_r;
  logic [MOVE_W-1:0]  mv_r;
  logic [6:0]         dep_r;
  logic [FLAG_W-1:0]  fl_r;
  logic [VALUE_W-1:0] val_r;
  logic [AW-1:0]      base;
  logic [WW-1:0]      rd_way, ev_way;
  logic               ev_valid;
  logic [AW-1:0]      clr_addr;
  logic               clr_op;

  logic signed [SCORE_W-1:0] top_score;
  entry_t                    best_e;
  logic [AW-1:0]             best_addr;

  entry_t        wr_e;
  logic [AW-1:0] wr_addr;

  logic        res_hit;
  entry_t      res_e;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd_e;
  logic [ENTRY_W-1:0] ram_rdata;

  chta_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e = entry_t'(ram_rdata);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = wr_e;
    ram_raddr = base + AW'(rd_way);
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = ENTRY_CLEAR;
    end else if (state == S_WRITE) begin
      ram_we = 1'b1;
    end
  end

  // way evaluation
  logic [AW-1:0]             ev_addr;
  logic signed [5:0]         age_raw, age_wrap;
  logic [4:0]                age;
  logic signed [SCORE_W-1:0] score_base, score;
  logic                      better, key_hit, last_way;
  entry_t                    vict_e;
  logic [AW-1:0]             vict_addr;
  logic signed [DEPTH_W-1:0] dnew;
  logic                      cnt_inc;
  logic [USED_W-1:0]         used_inc;
  entry_t                    upd_e, new_e;
  logic                      vict_write;

  always_comb begin
    ev_addr  = base + AW'(ev_way);
    age_raw  = $signed({2'b00, cur_date}) - $signed({2'b00, rd_e.date});
    age_wrap = (age_raw < 0) ? age_raw + 6'(AGE_SLOTS) : age_raw;
    age      = (age_wrap < 0) ? 5'd0 : age_wrap[4:0];
    score_base = $signed({3'b000, age, 8'h00}) - SCORE_W'(rd_e.depth);
    score = smart_replace ? (score_base <<< 2) - $signed({12'h000, rd_e.flags})
                          : score_base;
    better    = score > top_score;
    vict_e    = better ? rd_e : best_e;
    vict_addr = better ? ev_addr : best_addr;
    key_hit   = rd_e.key == key_r;
    last_way  = ev_way == WW'(WAYS - 1);
    dnew      = $signed({1'b0, dep_r});
    used_inc  = (&used_counter) ? used_counter : used_counter + 1'b1;

    upd_e = rd_e;
    if (rd_e.depth <= dnew) begin
      upd_e.move  = (smart_move && mv_r == '0) ? rd_e.move : mv_r;
      upd_e.depth = dnew;
      upd_e.flags = (smart_value && rd_e.depth == dnew && rd_e.value == val_r)
                    ? (fl_r | rd_e.flags) : fl_r;
      upd_e.value = val_r;
    end else if (smart_move && rd_e.move == '0) begin
      upd_e.move = mv_r;
    end
    upd_e.date = cur_date;

    new_e = '{key: key_r, move: mv_r, depth: dnew, date: cur_date, flags: fl_r,
              value: val_r};
    vict_write = (vict_e.date != cur_date) || always_write || !(vict_e.depth > dnew);
    cnt_inc    = key_hit ? (rd_e.date != cur_date) : (vict_e.date != cur_date);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      clr_op        <= 1'b0;
      smart_move    <= 1'b1;
      smart_value   <= 1'b0;
      smart_replace <= 1'b1;
      always_write  <= 1'b0;
      cur_date      <= '0;
      used_counter  <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SMART_MOVE:    smart_move    <= cfg_data;
          CFG_SMART_VALUE:   smart_value   <= cfg_data;
          CFG_SMART_REPLACE: smart_replace <= cfg_data;
          CFG_ALWAYS_WRITE:  always_write  <= cfg_data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= clr_op ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op_r       <= req.op;
            key_r      <= req.key;
            mv_r       <= req.move_in;
            dep_r      <= req.depth_in;
            fl_r       <= req.flags_in;
            val_r      <= req.value_in;
            base       <= AW'(req.key[INDEX_BITS-1:0]);
            rd_way     <= '0;
            ev_valid   <= 1'b0;
            top_score  <= SCORE_MIN;
            best_addr  <= AW'(req.key[INDEX_BITS-1:0]);
            res_hit    <= 1'b0;
            res_e      <= ENTRY_CLEAR;
            case (req.op)
              OP_STORE, OP_RETRIEVE: state <= S_SCAN;
              OP_ADVANCE: begin
                cur_date     <= (cur_date == DATE_W'(AGE_SLOTS - 1)) ? '0
                                : cur_date + 1'b1;
                used_counter <= '0;
                state        <= S_DONE;
              end
              default: begin
                cur_date     <= '0;
                used_counter <= '0;
                clr_addr     <= '0;
                clr_op       <= 1'b1;
                state        <= S_CLR;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_way < WW'(WAYS)) begin
            rd_way <= rd_way + 1'b1;
          end
          ev_valid <= rd_way < WW'(WAYS);
          ev_way   <= rd_way;
          if (ev_valid) begin
            top_score  <= better ? score : top_score;
            best_e     <= vict_e;
            best_addr  <= vict_addr;
            if (key_hit) begin
              if (op_r == OP_RETRIEVE) begin
                res_hit <= 1'b1;
                res_e   <= rd_e;
                state   <= S_DONE;
              end else begin
                wr_e    <= upd_e;
                wr_addr <= ev_addr;
                if (cnt_inc) used_counter <= used_inc;
                state   <= S_WRITE;
              end
            end else if (last_way) begin
              if (op_r == OP_RETRIEVE || !vict_write) begin
                state <= S_DONE;
              end else begin
                wr_e    <= new_e;
                wr_addr <= vict_addr;
                if (cnt_inc) used_counter <= used_inc;
                state   <= S_WRITE;
              end
            end
          end
        end
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.hit        <= res_hit;
      rsp.move_out   <= res_e.move;
      rsp.depth_out  <= res_e.depth;
      rsp.flags_out  <= res_e.flags;
      rsp.value_out  <= res_e.value;
      rsp.used_count <= used_counter;
    end
  end

  assign req.ready = (state == S_IDLE);

endmodule

FILE: rtl/chta_checker.sv
// ----------------------------------------------------------------------------
// chta_checker
// Port level checks of the clustered hash table core.
// ----------------------------------------------------------------------------
module chta_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_hit,
  input logic [15:0]       move_out,
  input logic signed [7:0] depth_out,
  input logic [3:0]        flags_out,
  input logic [15:0]       value_out,
  input logic [16:0]       used_count
);

  // reset starts the clearing sweep
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during clearing sweep");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_used_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(used_count))
    else $error("used count changed while stalled");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> depth_out == -8'sd128 && move_out == '0 &&
      flags_out == '0 && value_out == '0)
    else $error("miss response carries entry data");

endmodule

bind clustered_hash_table_age_replace_core chta_port_checker u_chta_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_hit    (rsp.hit),
  .move_out   (rsp.move_out),
  .depth_out  (rsp.depth_out),
  .flags_out  (rsp.flags_out),
  .value_out  (rsp.value_out),
  .used_count (rsp.used_count)
);
